// ===== sv/per_source_flood_limiter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-source flood limiter
// Shared assertion wrappers, sampled on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_FLOOD_LIMITER_TOP_MACROS_SVH
`define PER_SOURCE_FLOOD_LIMITER_TOP_MACROS_SVH

// plain property check, disabled while in reset
`define FSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication check built on the plain one
`define FSL_ASSERT_IMP(lbl, ante, cons, msg) \
  `FSL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== sv/fsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Flood limiter package
// Table sizes, register indexes, action codes and the structs passed
// between the controller and the cell row.
// ----------------------------------------------------------------------------
package fsl_pkg;

  // table geometry
  localparam int TABLE_DEPTH    = 64;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int SRC_W          = 16;
  localparam int TIME_W         = 32;
  localparam int CNT_W          = 24;
  localparam int WEIGHT_W       = 16;
  localparam int THR_W          = 16;
  localparam int WIN_W          = 16;
  localparam int FACT_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_W_PRIVMSG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_W_NOTICE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_W_TAGMSG  = 3'd7;

  // configured flood action codes
  localparam logic [FACT_W-1:0] FACT_BAN      = 3'd0;
  localparam logic [FACT_W-1:0] FACT_BLOCK    = 3'd1;
  localparam logic [FACT_W-1:0] FACT_KICK_BAN = 3'd4;

  // reported action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_BLOCK = 3'd2;

  // message kinds
  localparam logic [1:0] KIND_PRIVMSG = 2'd0;
  localparam logic [1:0] KIND_NOTICE  = 2'd1;
  localparam logic [1:0] KIND_TAGMSG  = 2'd2;

  // sweep token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic [CNT_W-1:0] found_count;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
  } token_t;

  // write command broadcast to all cells after a sweep
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              insert;
    logic              keep;
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] expiry;
    logic [CNT_W-1:0]  count;
  } wr_t;

endpackage

// ===== sv/fsl_cell.sv =====
// ----------------------------------------------------------------------------
// Flood limiter table cell
// Holds one source entry. Ages it out and matches it as the sweep token
// passes, then forwards the token through its register to the next cell.
// ----------------------------------------------------------------------------
module fsl_cell import fsl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [SRC_W-1:0]  src,
  input  logic [TIME_W-1:0] now,
  input  token_t            tok_in,
  output token_t            tok_out,
  input  wr_t               wr
);

  logic              valid;
  logic [SRC_W-1:0]  source;
  logic [TIME_W-1:0] expiry;
  logic [CNT_W-1:0]  count;
  token_t            tok;
  token_t            tok_next;

  logic expired;
  logic live;
  logic match;
  logic wr_hit;

  // entry status as seen by the passing token
  assign expired = valid && (expiry <= now);
  assign live    = valid && !expired;
  assign match   = live && (source == src);
  assign wr_hit  = wr.en && (wr.idx == cell_idx);

  // fold this entry into the token
  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.found       = 1'b1;
      tok_next.found_idx   = cell_idx;
      tok_next.found_count = count;
    end
    if (!live && !tok_in.have_free) begin
      tok_next.have_free = 1'b1;
      tok_next.free_idx  = cell_idx;
    end
  end

  // token stage and valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= '0;
      valid <= 1'b0;
    end else begin
      tok <= tok_next;
      if (wr_hit) begin
        valid <= wr.keep;
      end else if (tok_in.valid && expired) begin
        valid <= 1'b0;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      count <= wr.count;
      if (wr.insert) begin
        source <= wr.src;
        expiry <= wr.expiry;
      end
    end
  end

  assign tok_out = tok;

endmodule

// ===== sv/per_source_flood_limiter_top.sv =====
// ----------------------------------------------------------------------------
// Per-source flood limiter
// Fixed-window message counter per source, held in a row of table cells
// swept by a token for every checked message.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s        | in  | s_tvalid / s_tready  | s_tdata, s_tuser (message word)
//  m        | out | m_tvalid / m_tready  | m_tdata (verdict word)
//  cfg      | in  | cfg_we               | cfg_index, cfg_data
//
// One message at a time. A checked message sets launch_vld, then its
// token walks the cell row one cell a cycle and the verdict is
// registered at the end of the row. A message that bypasses the check goes
// straight to the result state. s_tready rises as the verdict word is loaded.
// rst clears the entry valid bits and handshakes, resets the configuration.
// A new message is taken while the previous verdict still waits on m_tready;
// its own verdict then waits in the result state until that one is taken.
// ----------------------------------------------------------------------------
module per_source_flood_limiter_top import fsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] source_id, [47:16] now_seconds, [48] from_local, [49] to_channel,
  // [50] exempt, [55:51] zero
  input  logic [55:0]           s_tdata,
  // [1:0] msg_kind
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] deny, [3:1] action_taken, [4] entry_cleared, [5] table_full, [7:6] zero
  output logic [7:0]            m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  // configuration registers
  logic                limiter_enabled;
  logic [THR_W-1:0]    message_threshold;
  logic [WIN_W-1:0]    window_seconds;
  logic [FACT_W-1:0]   flood_action;
  logic                reset_on_hit;
  logic [WEIGHT_W-1:0] weight_privmsg;
  logic [WEIGHT_W-1:0] weight_notice;
  logic [WEIGHT_W-1:0] weight_tagmsg;

  logic [1:0]          state;
  logic [SRC_W-1:0]    src_q;
  logic [TIME_W-1:0]   now_q;
  logic [1:0]          kind_q;
  logic                launch_vld;
  token_t              launch;
  token_t              tok [0:TABLE_DEPTH];
  token_t              tok_end;
  wr_t                 wr;
  wr_t                 wr_next;

  logic                res_deny, res_clr, res_full;
  logic [2:0]          res_act;
  logic                deny_next, clr_next, full_next;
  logic [2:0]          act_next;

  logic                accept;
  logic                checked;
  logic                sweep_done;
  logic                have_slot;
  logic [IDX_W-1:0]    slot;
  logic [CNT_W-1:0]    base_count;
  logic [WEIGHT_W-1:0] weight;
  logic [CNT_W:0]      sum_wide;
  logic [CNT_W-1:0]    sum_sat;
  logic [TIME_W:0]     exp_wide;
  logic [TIME_W-1:0]   exp_sat;
  logic                hit;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign checked  = limiter_enabled && s_tdata[48] && s_tdata[49] && !s_tdata[50];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_enabled   <= 1'b0;
      message_threshold <= THR_W'(5);
      window_seconds    <= WIN_W'(10);
      flood_action      <= FACT_BLOCK;
      reset_on_hit      <= 1'b1;
      weight_privmsg    <= WEIGHT_W'(256);
      weight_notice     <= WEIGHT_W'(256);
      weight_tagmsg     <= WEIGHT_W'(26);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:    limiter_enabled   <= cfg_data[0];
        CFG_THRESHOLD: message_threshold <= cfg_data[THR_W-1:0];
        CFG_WINDOW:    window_seconds    <= cfg_data[WIN_W-1:0];
        CFG_ACTION:    flood_action      <= cfg_data[FACT_W-1:0];
        CFG_RESET_HIT: reset_on_hit      <= cfg_data[0];
        CFG_W_PRIVMSG: weight_privmsg    <= cfg_data[WEIGHT_W-1:0];
        CFG_W_NOTICE:  weight_notice     <= cfg_data[WEIGHT_W-1:0];
        CFG_W_TAGMSG:  weight_tagmsg     <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // message fields held for the sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      src_q  <= s_tdata[SRC_W-1:0];
      now_q  <= s_tdata[47:16];
      kind_q <= s_tuser;
    end
  end

  // token injection into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      launch_vld <= 1'b0;
    end else begin
      launch_vld <= accept && checked;
    end
  end

  always_comb begin
    launch       = '0;
    launch.valid = launch_vld;
  end

  // cell row
  assign tok[0] = launch;
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    fsl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .src      (src_q),
      .now      (now_q),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .wr       (wr)
    );
  end
  assign tok_end    = tok[TABLE_DEPTH];
  assign sweep_done = (state == ST_SWEEP) && tok_end.valid;

  // weight lookup by kind
  always_comb begin
    case (kind_q)
      KIND_PRIVMSG: weight = weight_privmsg;
      KIND_NOTICE:  weight = weight_notice;
      KIND_TAGMSG:  weight = weight_tagmsg;
      default:      weight = '0;
    endcase
  end

  // count update, threshold compare and expiry of a new entry
  assign have_slot  = tok_end.found || tok_end.have_free;
  assign slot       = tok_end.found ? tok_end.found_idx : tok_end.free_idx;
  assign base_count = tok_end.found ? tok_end.found_count : '0;
  assign sum_wide   = {1'b0, base_count} + (CNT_W+1)'(weight);
  assign sum_sat    = sum_wide[CNT_W] ? COUNT_MAX : sum_wide[CNT_W-1:0];
  assign hit        = sum_sat >= {message_threshold, 8'h00};
  assign exp_wide   = {1'b0, now_q} + (TIME_W+1)'(window_seconds);
  assign exp_sat    = exp_wide[TIME_W] ? TIME_MAX : exp_wide[TIME_W-1:0];

  // verdict and write-back command
  always_comb begin
    deny_next = have_slot && hit;
    full_next = !have_slot;
    act_next  = ACT_NONE;
    clr_next  = 1'b0;
    if (deny_next) begin
      if (flood_action <= FACT_KICK_BAN && flood_action != FACT_BLOCK) begin
        act_next = flood_action + 3'd1;
        clr_next = reset_on_hit;
      end else begin
        act_next = ACT_BLOCK;
      end
    end
    wr_next        = '0;
    wr_next.en     = sweep_done && have_slot;
    wr_next.idx    = slot;
    wr_next.insert = !tok_end.found;
    wr_next.keep   = !clr_next;
    wr_next.src    = src_q;
    wr_next.expiry = exp_sat;
    wr_next.count  = sum_sat;
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      wr <= wr_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= checked ? ST_SWEEP : ST_RESULT;
          end
        end
        ST_SWEEP: begin
          if (sweep_done) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // verdict word handshake
      if (state == ST_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // verdict and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      res_deny <= 1'b0;
      res_act  <= ACT_NONE;
      res_clr  <= 1'b0;
      res_full <= 1'b0;
    end else if (sweep_done) begin
      res_deny <= deny_next;
      res_act  <= act_next;
      res_clr  <= clr_next;
      res_full <= full_next;
    end
    if (state == ST_RESULT && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, res_full, res_clr, res_act, res_deny};
    end
  end

  `include "per_source_flood_limiter_top_macros.svh"

  // the token only leaves the row during a sweep
  `FSL_ASSERT_IMP(a_tok_in_sweep, tok_end.valid, state == ST_SWEEP,
                  "sweep token left the row outside a sweep")
  // a verdict only appears out of the result state
  `FSL_ASSERT_IMP(a_result_src, $rose(m_tvalid), $past(state) == ST_RESULT,
                  "verdict raised outside the result state")
  // a pass carries no action and no clear
  `FSL_ASSERT_IMP(a_pass_clean, m_tvalid && !m_tdata[0],
                  m_tdata[3:1] == ACT_NONE && !m_tdata[4],
                  "passed message reports an action")
  // a full table never denies
  `FSL_ASSERT_IMP(a_full_pass, m_tvalid && m_tdata[5], !m_tdata[0],
                  "full table reported together with deny")
  // write-back follows the end of a sweep
  `FSL_ASSERT_IMP(a_wr_after_sweep, wr.en, $past(sweep_done),
                  "table write without a finished sweep")

endmodule

// ===== tb/flood_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// Flood limiter verdict checker
// Watches the message, verdict and register channels of the flood limiter.
// Keeps its own copy of the registers and of the per-source counter table,
// works out the verdict for every accepted message word and compares each
// verdict word field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module flood_verdict_checker import fsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // [15:0] source_id, [47:16] now_seconds, [48] from_local, [49] to_channel,
  // [50] exempt, [55:51] zero
  input  logic [55:0]           s_tdata,
  // [1:0] msg_kind
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] deny, [3:1] action_taken, [4] entry_cleared, [5] table_full, [7:6] zero
  input  logic [7:0]            m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    verdicts_owed
);

  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [1:0]        kind;
    logic [TIME_W-1:0] now;
    logic              from_local;
    logic              to_channel;
    logic              exempt;
  } message_t;

  typedef struct packed {
    logic       deny;
    logic [2:0] action;
    logic       cleared;
    logic       full;
  } verdict_t;

  // shadow of the register file
  logic                lim_on;
  logic [THR_W-1:0]    lim_threshold;
  logic [WIN_W-1:0]    lim_window;
  logic [FACT_W-1:0]   lim_action;
  logic                lim_clear_on_hit;
  logic [WEIGHT_W-1:0] weight_priv;
  logic [WEIGHT_W-1:0] weight_note;
  logic [WEIGHT_W-1:0] weight_tag;

  // shadow of the per-source counter table
  logic              slot_used   [TABLE_DEPTH];
  logic [SRC_W-1:0]  slot_source [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_expiry [TABLE_DEPTH];
  logic [CNT_W-1:0]  slot_count  [TABLE_DEPTH];

  // outstanding verdicts, oldest at the read pointer
  verdict_t   due_verdicts [0:7];
  logic [2:0] due_wr;
  logic [2:0] due_rd;
  int         due_level;

  // sweep, look up or insert, add the weight and decide
  function automatic verdict_t judge_message(input message_t msg);
    verdict_t            v;
    int                  hit_slot;
    int                  free_slot;
    logic [TIME_W:0]     ends;
    logic [CNT_W:0]      total;
    logic [WEIGHT_W-1:0] w;
    v = '0;
    hit_slot = -1;
    free_slot = -1;
    if (!lim_on || !msg.from_local || !msg.to_channel || msg.exempt) return v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i] && slot_expiry[i] <= msg.now) slot_used[i] = 1'b0;
      if (slot_used[i]) begin
        if (slot_source[i] == msg.source) hit_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    // new source takes the lowest free slot, expiry saturating at the top
    if (hit_slot < 0 && free_slot >= 0) begin
      ends = {1'b0, msg.now} + (TIME_W+1)'(lim_window);
      if (ends[TIME_W]) ends = {1'b0, TIME_MAX};
      hit_slot = free_slot;
      slot_used[hit_slot] = 1'b1;
      slot_source[hit_slot] = msg.source;
      slot_expiry[hit_slot] = ends[TIME_W-1:0];
      slot_count[hit_slot] = '0;
    end
    if (hit_slot < 0) begin
      v.full = 1'b1;
    end else begin
      case (msg.kind)
        KIND_PRIVMSG: w = weight_priv;
        KIND_NOTICE:  w = weight_note;
        KIND_TAGMSG:  w = weight_tag;
        default:      w = '0;
      endcase
      total = {1'b0, slot_count[hit_slot]} + (CNT_W+1)'(w);
      if (total[CNT_W]) total = {1'b0, COUNT_MAX};
      slot_count[hit_slot] = total[CNT_W-1:0];
      if (total[CNT_W-1:0] >= {lim_threshold, 8'h00}) begin
        v.deny = 1'b1;
        if (lim_action <= FACT_KICK_BAN && lim_action != FACT_BLOCK) begin
          v.action = lim_action + 3'd1;
          if (lim_clear_on_hit) begin
            slot_used[hit_slot] = 1'b0;
            v.cleared = 1'b1;
          end
        end else begin
          v.action = ACT_BLOCK;
        end
      end
    end
    return v;
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: verdict %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // watch all three channels on every edge
  always @(posedge clk) begin : watch_channels
    message_t msg;
    verdict_t want;
    verdict_t got;
    if (rst) begin
      lim_on = 1'b0;
      lim_threshold = 16'd5;
      lim_window = 16'd10;
      lim_action = FACT_BLOCK;
      lim_clear_on_hit = 1'b1;
      weight_priv = 16'd256;
      weight_note = 16'd256;
      weight_tag = 16'd26;
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      due_wr = '0;
      due_rd = '0;
      due_level = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:    lim_on = cfg_data[0];
          CFG_THRESHOLD: lim_threshold = cfg_data;
          CFG_WINDOW:    lim_window = cfg_data;
          CFG_ACTION:    lim_action = cfg_data[FACT_W-1:0];
          CFG_RESET_HIT: lim_clear_on_hit = cfg_data[0];
          CFG_W_PRIVMSG: weight_priv = cfg_data;
          CFG_W_NOTICE:  weight_note = cfg_data;
          CFG_W_TAGMSG:  weight_tag = cfg_data;
          default: ;
        endcase
      end
      // accepted message word
      if (s_tvalid && s_tready) begin
        msg.source = s_tdata[15:0];
        msg.now = s_tdata[47:16];
        msg.from_local = s_tdata[48];
        msg.to_channel = s_tdata[49];
        msg.exempt = s_tdata[50];
        msg.kind = s_tuser;
        due_verdicts[due_wr] = judge_message(msg);
        due_wr = due_wr + 3'd1;
        due_level++;
      end
      // accepted verdict word
      if (m_tvalid && m_tready) begin
        got.deny = m_tdata[0];
        got.action = m_tdata[3:1];
        got.cleared = m_tdata[4];
        got.full = m_tdata[5];
        if (due_level == 0) begin
          $display("%0t: verdict word with nothing outstanding, expected none, got %h",
                   $time, m_tdata);
          mismatch_count++;
        end else begin
          want = due_verdicts[due_rd];
          due_rd = due_rd + 3'd1;
          due_level--;
          check_field("deny", int'(want.deny), int'(got.deny));
          check_field("action_taken", int'(want.action), int'(got.action));
          check_field("entry_cleared", int'(want.cleared), int'(got.cleared));
          check_field("table_full", int'(want.full), int'(got.full));
        end
      end
    end
    verdicts_owed <= due_level;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Flood limiter testbench
// Drives message words and register writes into the per-source flood
// limiter with random gaps and back-pressure, a directed opening and then
// random phases of mixed settings, a table-filling phase and a count
// saturation phase. The verdict checker beside the block does the checking.
// ----------------------------------------------------------------------------
module testbench;
  import fsl_pkg::*;

  // action and kind codes not named in the package
  localparam logic [FACT_W-1:0] FACT_MUTE  = 3'd2;
  localparam logic [FACT_W-1:0] FACT_KICK  = 3'd3;
  localparam logic [FACT_W-1:0] FACT_SPARE = 3'd7;
  localparam logic [1:0]        KIND_SPARE = 2'd3;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [55:0]           s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatch_count;
  int                    verdicts_owed;

  bit                    tx_calm = 1'b0;
  bit                    rx_calm = 1'b0;
  bit                    hold_req = 1'b0;
  logic [TIME_W-1:0]     wall;
  logic [SRC_W-1:0]      talkers [8];

  per_source_flood_limiter_top dut (.*);

  flood_verdict_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  // verdict side: random stalls, long hold on request
  initial begin : receiver
    int stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 600;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (rx_calm || r < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 120);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(30, 200);
  endfunction

  // offer one message word and wait for it to be taken
  task automatic send_msg(input logic [SRC_W-1:0] src, input logic [1:0] kind,
                          input logic [TIME_W-1:0] now, input logic lcl,
                          input logic chan, input logic exm);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {5'd0, exm, chan, lcl, now, src};
    s_tuser <= kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait until every verdict is in
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random settings, extremes included
  task automatic pick_settings();
    logic [15:0] w [3];
    logic [15:0] thr;
    logic [15:0] win;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 4))
        0: w[k] = 16'd256;
        1: w[k] = 16'd26;
        2: w[k] = 16'd0;
        3: w[k] = 16'hFFFF;
        default: w[k] = 16'($urandom);
      endcase
    end
    case ($urandom_range(0, 9))
      0: thr = 16'($urandom_range(0, 1));
      1: thr = 16'hFFFF;
      2: thr = 16'($urandom_range(7, 300));
      default: thr = 16'($urandom_range(2, 6));
    endcase
    case ($urandom_range(0, 5))
      0: win = 16'($urandom_range(0, 1));
      1: win = 16'hFFFF;
      2, 3: win = 16'($urandom_range(2, 20));
      default: win = 16'($urandom_range(20, 200));
    endcase
    write_reg(CFG_ENABLE, CFG_DATA_W'($urandom_range(0, 9) != 0));
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_ACTION, CFG_DATA_W'($urandom_range(0, 7)));
    write_reg(CFG_RESET_HIT, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(CFG_W_PRIVMSG, w[0]);
    write_reg(CFG_W_NOTICE, w[1]);
    write_reg(CFG_W_TAGMSG, w[2]);
  endtask

  // mostly checked traffic from a few talkers, some bypass noise and strays
  task automatic run_mix(input int count, input bit squeeze);
    int         npool;
    int         r;
    logic [1:0] kind;
    logic [2:0] flags;
    npool = $urandom_range(1, 6);
    for (int k = 0; k < npool; k++) talkers[k] = SRC_W'($urandom);
    wall = wall + 32'd70000;
    tx_calm = squeeze || ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    if (squeeze) hold_req = 1'b1;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      kind = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 15) == 0) kind = KIND_SPARE;
      wall = wall + $urandom_range(0, 2);
      if ($urandom_range(0, 19) == 0) wall = wall + $urandom_range(1, 40);
      if (r < 80) begin
        send_msg(talkers[$urandom_range(0, npool - 1)], kind, wall, 1'b1, 1'b1, 1'b0);
      end else if (r < 90) begin
        // flags are {exempt, to_channel, from_local}; never the checked pattern
        flags = 3'($urandom_range(0, 7));
        if (flags == 3'b011) flags = 3'b111;
        kind = 2'($urandom_range(0, 3));
        send_msg(SRC_W'($urandom), kind, $urandom, flags[0], flags[1], flags[2]);
      end else begin
        send_msg(SRC_W'($urandom), kind, wall, 1'b1, 1'b1, 1'b0);
      end
    end
    settle();
  endtask

  // distinct sources until the table runs out of slots
  task automatic run_crowd(input int count);
    logic [SRC_W-1:0] base;
    logic [1:0]       kind;
    base = SRC_W'($urandom);
    wall = wall + 32'd70000;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_WINDOW, 16'hFFFF);
    write_reg(CFG_W_TAGMSG, CFG_DATA_W'($urandom_range(0, 64)));
    for (int n = 0; n < count; n++) begin
      kind = 2'($urandom_range(0, 3));
      wall = wall + $urandom_range(0, 1);
      send_msg(SRC_W'(base + n), kind, wall, 1'b1, 1'b1, 1'b0);
    end
    settle();
  endtask

  // one source at full weight until the count pins at its ceiling
  task automatic run_pileup(input int count);
    logic [SRC_W-1:0] src;
    logic [1:0]       kind;
    src = SRC_W'($urandom);
    wall = wall + 32'd70000;
    tx_calm = ($urandom_range(0, 1) == 0);
    rx_calm = ($urandom_range(0, 1) == 0);
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_WINDOW, 16'hFFFF);
    write_reg(CFG_ACTION, CFG_DATA_W'(FACT_BLOCK));
    write_reg(CFG_RESET_HIT, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(CFG_W_PRIVMSG, 16'hFFFF);
    write_reg(CFG_W_NOTICE, 16'hFFFF);
    write_reg(CFG_W_TAGMSG, 16'hFFFF);
    for (int n = 0; n < count; n++) begin
      kind = 2'($urandom_range(0, 2));
      wall = wall + $urandom_range(0, 1);
      send_msg(src, kind, wall, 1'b1, 1'b1, 1'b0);
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // limiter off after reset: passes untouched
    send_msg(16'h0000, KIND_PRIVMSG, 32'd0, 1'b1, 1'b1, 1'b0);
    settle();

    // ban on the second message, then the bypass conditions
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_THRESHOLD, 16'd2);
    write_reg(CFG_WINDOW, 16'd10);
    write_reg(CFG_ACTION, CFG_DATA_W'(FACT_BAN));
    write_reg(CFG_RESET_HIT, 16'd1);
    send_msg(16'hFFFF, KIND_PRIVMSG, 32'd100, 1'b1, 1'b1, 1'b0);
    send_msg(16'hFFFF, KIND_PRIVMSG, 32'd101, 1'b1, 1'b1, 1'b0);
    send_msg(16'hFFFF, KIND_PRIVMSG, 32'd102, 1'b1, 1'b1, 1'b0);
    send_msg(16'hFFFF, KIND_PRIVMSG, 32'd102, 1'b0, 1'b1, 1'b0);
    send_msg(16'hFFFF, KIND_PRIVMSG, 32'd102, 1'b1, 1'b0, 1'b0);
    send_msg(16'hFFFF, KIND_PRIVMSG, 32'd102, 1'b1, 1'b1, 1'b1);
    send_msg(16'hFFFF, KIND_NOTICE, 32'd103, 1'b1, 1'b1, 1'b0);
    send_msg(16'h1234, KIND_TAGMSG, 32'd104, 1'b1, 1'b1, 1'b0);
    send_msg(16'h1234, KIND_SPARE, 32'd105, 1'b1, 1'b1, 1'b0);
    // past the window: everything swept away
    send_msg(16'h1234, KIND_PRIVMSG, 32'd200, 1'b1, 1'b1, 1'b0);
    settle();

    // zero window, zero threshold, spare action code
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_ACTION, CFG_DATA_W'(FACT_SPARE));
    send_msg(16'h00FF, KIND_SPARE, 32'd300, 1'b1, 1'b1, 1'b0);
    send_msg(16'h00FF, KIND_PRIVMSG, 32'd300, 1'b1, 1'b1, 1'b0);
    settle();

    // expiry pinned at the top of the clock
    write_reg(CFG_WINDOW, 16'hFFFF);
    write_reg(CFG_THRESHOLD, 16'd2);
    write_reg(CFG_ACTION, CFG_DATA_W'(FACT_MUTE));
    send_msg(16'hAAAA, KIND_PRIVMSG, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0);
    send_msg(16'hAAAA, KIND_PRIVMSG, 32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0);
    settle();

    // kick with extreme weights and threshold one
    write_reg(CFG_WINDOW, 16'd10);
    write_reg(CFG_THRESHOLD, 16'd1);
    write_reg(CFG_ACTION, CFG_DATA_W'(FACT_KICK));
    write_reg(CFG_W_PRIVMSG, 16'hFFFF);
    write_reg(CFG_W_NOTICE, 16'd0);
    write_reg(CFG_W_TAGMSG, 16'd1);
    send_msg(16'h0F0F, KIND_PRIVMSG, 32'd7, 1'b1, 1'b1, 1'b0);
    send_msg(16'h0F0F, KIND_NOTICE, 32'd7, 1'b1, 1'b1, 1'b0);
    send_msg(16'h0F0F, KIND_TAGMSG, 32'd8, 1'b1, 1'b1, 1'b0);
    settle();

    // kick and ban, counter kept
    write_reg(CFG_THRESHOLD, 16'd2);
    write_reg(CFG_ACTION, CFG_DATA_W'(FACT_KICK_BAN));
    write_reg(CFG_RESET_HIT, 16'd0);
    write_reg(CFG_W_PRIVMSG, 16'd256);
    send_msg(16'hF0F0, KIND_PRIVMSG, 32'd9, 1'b1, 1'b1, 1'b0);
    send_msg(16'hF0F0, KIND_PRIVMSG, 32'd9, 1'b1, 1'b1, 1'b0);
    send_msg(16'hF0F0, KIND_PRIVMSG, 32'd10, 1'b1, 1'b1, 1'b0);
    settle();

    // random phases
    wall = $urandom_range(0, 32'h4000_0000);
    pick_settings();
    run_mix(30, 1'b0);
    pick_settings();
    run_mix(30, 1'b1);
    run_crowd(80);
    pick_settings();
    run_mix(30, 1'b0);
    run_pileup(260);
    repeat (4) begin
      pick_settings();
      run_mix(30, 1'b0);
    end

    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== per_source_flood_limiter_top.f =====
+incdir+sv
sv/fsl_pkg.sv
sv/fsl_cell.sv
sv/per_source_flood_limiter_top.sv
tb/flood_verdict_checker.sv
tb/testbench.sv
